// File: rtl/iptom_pkg.sv
`default_nettype none

package iptom_pkg;

  // One input word as it travels from the input register to the walker.
  typedef struct packed {
    logic [7:0] option_byte;
    logic       last_byte;
  } iptom_item_t;

  // Walk phases, one-hot.
  typedef enum logic [3:0] {
    PH_KIND = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_SKIP = 4'b0100,
    PH_DONE = 4'b1000
  } iptom_phase_t;

  localparam logic MODE_IPV4 = 1'b0;
  localparam logic MODE_TCP  = 1'b1;

  localparam logic [7:0] KIND_EOL  = 8'd0;
  localparam logic [7:0] KIND_NOP  = 8'd1;
  localparam logic [7:0] KIND_IP4_RR = 8'd7;
  localparam logic [7:0] MIN_OPT_LEN = 8'd2;

  // Mask bit for one option kind. IPv4 kinds go through a fixed map to
  // IPFIX bit positions; TCP kinds below 32 set bit (32 - kind) mod 32.
  function automatic logic [31:0] kind_bit(input logic mode, input logic [7:0] kind);
    logic [4:0] pos;
    logic       hit;
    pos = 5'd0;
    hit = 1'b0;
    if (mode == MODE_TCP) begin
      hit = (kind[7:5] == 3'd0);
      pos = 5'd0 - kind[4:0];
    end else begin
      hit = 1'b1;
      unique case (kind) inside
        8'd0:                      pos = 5'd25;
        8'd1:                      pos = 5'd26;
        KIND_IP4_RR:               pos = 5'd0;
        8'd10:                     pos = 5'd19;
        8'd11:                     pos = 5'd20;
        8'd12:                     pos = 5'd21;
        8'd15:                     pos = 5'd24;
        8'd25:                     pos = 5'd2;
        8'd30, 8'd94, 8'd158, 8'd222: pos = 5'd7;
        8'd68:                     pos = 5'd29;
        8'd82:                     pos = 5'd11;
        8'd130:                    pos = 5'd27;
        8'd131:                    pos = 5'd28;
        8'd133:                    pos = 5'd30;
        8'd134:                    pos = 5'd31;
        8'd136:                    pos = 5'd17;
        8'd137:                    pos = 5'd18;
        8'd142:                    pos = 5'd23;
        8'd144:                    pos = 5'd9;
        8'd145:                    pos = 5'd10;
        8'd147:                    pos = 5'd13;
        8'd148:                    pos = 5'd12;
        8'd149:                    pos = 5'd14;
        8'd150:                    pos = 5'd15;
        8'd151:                    pos = 5'd16;
        8'd152:                    pos = 5'd1;
        8'd205:                    pos = 5'd22;
        default:                   hit = 1'b0;
      endcase
    end
    kind_bit = hit ? (32'd1 << pos) : 32'd0;
  endfunction

endpackage

`default_nettype wire

// File: rtl/iptom_in_if.sv
`default_nettype none

interface iptom_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] option_byte;
  logic       last_byte;

  modport source (output valid, output option_byte, output last_byte, input ready);
  modport sink (input valid, input option_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/iptom_out_if.sv
`default_nettype none

interface iptom_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] option_mask;

  modport source (output valid, output option_mask, input ready);
  modport sink (input valid, input option_mask, output ready);
endinterface

`default_nettype wire

// File: rtl/iptom_in_stage.sv
`default_nettype none

module iptom_in_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  iptom_in_if.sink                in_ch,
  input  wire logic               advance,
  output logic                    item_valid,
  output iptom_pkg::iptom_item_t  item
);
  import iptom_pkg::*;

  logic        valid_r;
  iptom_item_t item_r;

  // The register takes a new word whenever it is empty or its word moves on.
  assign in_ch.ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.option_byte <= in_ch.option_byte;
      item_r.last_byte   <= in_ch.last_byte;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// File: rtl/iptom_walk.sv
`default_nettype none

module iptom_walk (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step,
  input  wire iptom_pkg::iptom_item_t item,
  input  wire logic                   mode,
  output logic [31:0]                 mask_out
);
  import iptom_pkg::*;

  iptom_phase_t phase_r, phase_nxt;
  logic [7:0]   skip_r, skip_nxt;
  logic [31:0]  mask_r, mask_nxt;
  logic [7:0]   len_rem;
  logic [7:0]   skip_dec;

  assign len_rem  = item.option_byte - MIN_OPT_LEN;
  assign skip_dec = skip_r - 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    skip_nxt  = skip_r;
    mask_nxt  = mask_r;
    unique case (phase_r)
      PH_KIND: begin
        mask_nxt = mask_r | kind_bit(mode, item.option_byte);
        if (item.option_byte == KIND_EOL) begin
          phase_nxt = PH_DONE;
        end else if (item.option_byte != KIND_NOP) begin
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        if (item.option_byte < MIN_OPT_LEN) begin
          phase_nxt = PH_DONE;
        end else begin
          skip_nxt  = len_rem;
          phase_nxt = (len_rem != 8'd0) ? PH_SKIP : PH_KIND;
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == 8'd0) begin
          phase_nxt = PH_KIND;
        end
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_KIND;
      end
    endcase
  end

  // The emitted mask includes the bit of a kind that arrives on the last byte.
  assign mask_out = mask_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_KIND;
      skip_r  <= 8'd0;
      mask_r  <= 32'd0;
    end else if (step) begin
      if (item.last_byte) begin
        phase_r <= PH_KIND;
        skip_r  <= 8'd0;
        mask_r  <= 32'd0;
      end else begin
        phase_r <= phase_nxt;
        skip_r  <= skip_nxt;
        mask_r  <= mask_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/ip_tcp_option_mask_core.sv
`default_nettype none

// Option-kind mask builder for IPv4 or TCP header option areas.
//
// The input channel carries one byte of the option area per word, with
// last_byte marking the final byte of the area. The output channel carries
// one 32-bit option mask per area, sent for the word that has last_byte set;
// all other words produce no output word.
// cfg_we/cfg_wdata write the one-bit mode register: 0 maps IPv4 option kinds,
// 1 maps TCP option kinds. Write it only while no area is in flight.
//
// A word passes through an input register and then the walker, whose state
// and mask update is one short step of logic, into the output register. One
// word is accepted every cycle when the receiver keeps up.
//
// When the receiver stalls, a finished mask waits in the output register.
// Non-last words keep flowing into the walker meanwhile; a second last byte
// waits in the input register until the pending mask is taken, and input
// ready then drops.
// Synchronous active-low reset empties both registers, returns the walk to
// expecting an option kind with an empty mask, and selects IPv4 mode.

module ip_tcp_option_mask_core (
  input  wire logic clk,
  input  wire logic rst_n,
  iptom_in_if.sink  in_ch,
  iptom_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata
);
  import iptom_pkg::*;

  logic        mode_r;
  logic        item_valid;
  iptom_item_t item;
  logic        advance;
  logic [31:0] mask_out;
  logic        out_valid_r;
  logic [31:0] out_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IPV4;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // A word leaves the input register unless it would emit a mask while the
  // output register still holds one that has not been taken.
  assign advance = item_valid && (!item.last_byte || !out_valid_r || out_ch.ready);

  iptom_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  iptom_walk u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .item     (item),
    .mode     (mode_r),
    .mask_out (mask_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && item.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.last_byte) begin
      out_mask_r <= mask_out;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.option_mask = out_mask_r;

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`default_nettype none

module testbench;
  import iptom_pkg::*;

  // A directed row either sends one word or rewrites the mode register once
  // the block has drained.
  typedef enum logic {
    ROW_WORD,
    ROW_MODE
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  data;
    logic        last;
    logic        typed;
    logic [31:0] mask;
  } script_row_t;

  // How the receiver treats the output channel over one stretch of cycles.
  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_HEAVY
  } stall_style_t;

  // Directed words. Rows marked typed carry a mask read straight off the
  // option definitions; the other rows are checked against the predictor.
  localparam int N_SCRIPT = 28;
  localparam script_row_t SCRIPT [N_SCRIPT] = '{
    // IPv4: record route alone, then end of list alone.
    '{ROW_WORD, 8'd7,   1'b1, 1'b1, 32'h0000_0001},
    '{ROW_WORD, 8'd0,   1'b1, 1'b1, 32'h0200_0000},
    // Unmapped top kind with the shortest legal length, a NOP, and a kind
    // on the last word.
    '{ROW_WORD, 8'd255, 1'b0, 1'b0, 32'h0},
    '{ROW_WORD, 8'd2,   1'b0, 1'b0, 32'h0},
    '{ROW_WORD, 8'd1,   1'b0, 1'b0, 32'h0},
    '{ROW_WORD, 8'd134, 1'b1, 1'b1, 32'h8400_0000},
    // A length below two stops the walk; the last word is then ignored.
    '{ROW_WORD, 8'd68,  1'b0, 1'b0, 32'h0},
    '{ROW_WORD, 8'd1,   1'b0, 1'b0, 32'h0},
    '{ROW_WORD, 8'd7,   1'b1, 1'b1, 32'h2000_0000},
    // The largest length runs past the end of the area.
    '{ROW_WORD, 8'd130, 1'b0, 1'b0, 32'h0},
    '{ROW_WORD, 8'd255, 1'b0, 1'b0, 32'h0},
    '{ROW_WORD, 8'd7,   1'b1, 1'b1, 32'h0800_0000},
    // One data word skipped, then end of list as the last word.
    '{ROW_WORD, 8'd152, 1'b0, 1'b0, 32'h0},
    '{ROW_WORD, 8'd3,   1'b0, 1'b0, 32'h0},
    '{ROW_WORD, 8'd0,   1'b0, 1'b0, 32'h0},
    '{ROW_WORD, 8'd0,   1'b1, 1'b1, 32'h0200_0002},
    // The area ends on a length word of zero.
    '{ROW_WORD, 8'd25,  1'b0, 1'b0, 32'h0},
    '{ROW_WORD, 8'd0,   1'b1, 1'b1, 32'h0000_0004},
    // The mode switches to TCP in the middle of an area.
    '{ROW_WORD, 8'd222, 1'b0, 1'b0, 32'h0},
    '{ROW_WORD, 8'd2,   1'b0, 1'b0, 32'h0},
    '{ROW_MODE, 8'(MODE_TCP), 1'b0, 1'b0, 32'h0},
    '{ROW_WORD, 8'd1,   1'b0, 1'b0, 32'h0},
    '{ROW_WORD, 8'd31,  1'b0, 1'b0, 32'h0},
    '{ROW_WORD, 8'd2,   1'b0, 1'b0, 32'h0},
    '{ROW_WORD, 8'd0,   1'b1, 1'b0, 32'h0},
    // TCP kinds from 32 up set nothing.
    '{ROW_WORD, 8'd32,  1'b0, 1'b0, 32'h0},
    '{ROW_WORD, 8'd2,   1'b0, 1'b0, 32'h0},
    '{ROW_WORD, 8'd255, 1'b1, 1'b1, 32'h0}
  };

  localparam int N_RANDOM_PHASES = 4;
  localparam int WORDS_PER_PHASE = 250;
  // After the last byte is taken, its mask still passes the walker into the
  // output register; the drain gives the pipeline ample room to empty.
  localparam int DRAIN_CYCLES = 4;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  iptom_in_if  in_ch();
  iptom_out_if out_ch();

  ip_tcp_option_mask_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: the mode register and the option walk, kept apart from
  // the block and advanced on every word that the block accepts.
  logic         opt_mode = MODE_IPV4;
  iptom_phase_t walk_ph = PH_KIND;
  logic [7:0]   skip_left = 8'd0;
  logic [31:0]  mask_acc = 32'd0;

  // Masks still owed by the block, oldest first.
  logic [31:0]  masks_due[$];
  bit           mismatch_seen = 1'b0;
  int           burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Generous ceiling on the whole run; a correct run ends far earlier.
  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

  // IPFIX rank of an IPv4 option kind. The mask bit is 32 minus the rank;
  // a rank of zero means the kind has no bit.
  function automatic int ipv4_rank(input logic [7:0] kind);
    case (kind)
      8'd0:   return 7;
      8'd1:   return 6;
      8'd10:  return 13;
      8'd11:  return 12;
      8'd12:  return 11;
      8'd15:  return 8;
      8'd25:  return 30;
      8'd30:  return 25;
      8'd68:  return 3;
      8'd82:  return 21;
      8'd94:  return 25;
      8'd130: return 5;
      8'd131: return 4;
      8'd133: return 2;
      8'd134: return 1;
      8'd136: return 15;
      8'd137: return 14;
      8'd142: return 9;
      8'd144: return 23;
      8'd145: return 22;
      8'd147: return 19;
      8'd148: return 20;
      8'd149: return 18;
      8'd150: return 17;
      8'd151: return 16;
      8'd152: return 31;
      8'd158: return 25;
      8'd205: return 10;
      8'd222: return 25;
      default: return 0;
    endcase
  endfunction

  function automatic logic [31:0] kind_mask(input logic mode, input logic [7:0] kind);
    int rank;
    // TCP kind k lands on bit 32 - k, wrapping so that kind 0 lands on bit 0.
    if (mode == MODE_TCP) begin
      return (kind < 8'd32) ? 32'd1 << ((32 - int'(kind)) % 32) : 32'd0;
    end
    if (kind == KIND_IP4_RR) begin
      return 32'd1;
    end
    rank = ipv4_rank(kind);
    return (rank == 0) ? 32'd0 : 32'd1 << (32 - rank);
  endfunction

  // Advances the walk by one accepted word. On the last word of an area it
  // hands back the finished mask and restarts the walk.
  function automatic void walk_word(input logic [7:0] b, input logic last,
                                    output logic done, output logic [31:0] mask);
    done = 1'b0;
    mask = 32'd0;
    case (walk_ph)
      PH_KIND: begin
        mask_acc |= kind_mask(opt_mode, b);
        if (b == KIND_EOL) begin
          walk_ph = PH_DONE;
        end else if (b != KIND_NOP) begin
          walk_ph = PH_LEN;
        end
      end
      PH_LEN: begin
        if (b < MIN_OPT_LEN) begin
          walk_ph = PH_DONE;
        end else begin
          skip_left = b - MIN_OPT_LEN;
          walk_ph = (skip_left != 8'd0) ? PH_SKIP : PH_KIND;
        end
      end
      PH_SKIP: begin
        skip_left = skip_left - 8'd1;
        if (skip_left == 8'd0) begin
          walk_ph = PH_KIND;
        end
      end
      default: ;
    endcase
    if (last) begin
      done = 1'b1;
      mask = mask_acc;
      walk_ph = PH_KIND;
      skip_left = 8'd0;
      mask_acc = 32'd0;
    end
  endfunction

  // Sends one word and returns at the edge where it is taken. The sender
  // works in bursts; a fresh burst may start after a random gap, and now
  // and then a long burst runs with no gap at all.
  task automatic push_word(input logic [7:0] b, input logic last,
                           output logic done, output logic [31:0] mask);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) == 0) begin
        burst_left = $urandom_range(100, 300);
      end else begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(0, 5);
      end
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.option_byte <= b;
    in_ch.last_byte <= last;
    do @(posedge clk); while (!in_ch.ready);
    walk_word(b, last, done, mask);
  endtask

  // Lets every owed mask arrive, then gives the pipeline time to settle so
  // that words which make no mask have also left it.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (masks_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    opt_mode = mode;
  endtask

  // Kind for a well-formed option: NOPs and end of list now and then, TCP
  // kinds around the mapped range, IPv4 kinds either mapped or anything.
  function automatic logic [7:0] pick_kind();
    int         r;
    logic [7:0] k;
    r = $urandom_range(0, 9);
    if (r < 2) return KIND_NOP;
    if (r == 2) return KIND_EOL;
    if (opt_mode == MODE_TCP) return 8'($urandom_range(2, 40));
    if (r < 6) return 8'($urandom_range(0, 255));
    do k = 8'($urandom_range(0, 222));
    while (k != KIND_IP4_RR && ipv4_rank(k) == 0);
    return k;
  endfunction

  // One option area. Most areas are well formed with random content, so the
  // walk reaches its length and skip phases; the rest are raw noise that
  // breaks lengths, stops early or cuts options off.
  task automatic send_random_area(output int sent);
    logic [7:0]  area[$];
    logic [7:0]  kind;
    logic        done;
    logic [31:0] mask;
    int          len;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 12)) area.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 5)) begin
        kind = pick_kind();
        area.push_back(kind);
        if (kind == KIND_EOL) begin
          repeat ($urandom_range(0, 3)) area.push_back(8'($urandom_range(0, 255)));
          break;
        end
        if (kind != KIND_NOP) begin
          len = ($urandom_range(0, 15) == 0) ? $urandom_range(2, 40)
                                             : $urandom_range(2, 6);
          area.push_back(8'(len));
          repeat (len - 2) area.push_back(8'($urandom_range(0, 255)));
        end
      end
    end
    foreach (area[i]) begin
      push_word(area[i], i == area.size() - 1, done, mask);
      if (done) masks_due.push_back(mask);
    end
    sent = area.size();
  endtask

  // The receiver switches between stretches of steady readiness, coin-flip
  // readiness and heavy stalls. Heavy stalls let a finished mask sit in the
  // output register while a second last byte backs up the input side.
  initial begin : receiver
    stall_style_t style;
    int           style_left;
    style = STALL_NONE;
    style_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (style_left == 0) begin
        style = stall_style_t'($urandom_range(0, 2));
        style_left = $urandom_range(10, 150);
      end
      style_left--;
      case (style)
        STALL_NONE:   out_ch.ready <= 1'b1;
        STALL_RANDOM: out_ch.ready <= 1'($urandom_range(0, 1));
        default:      out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Every mask taken from the block is matched against the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (masks_due.size() == 0) begin
        $error("option_mask: expected none, actual %h", out_ch.option_mask);
        mismatch_seen = 1'b1;
      end else begin
        if (out_ch.option_mask !== masks_due[0]) begin
          $error("option_mask: expected %h, actual %h", masks_due[0],
                 out_ch.option_mask);
          mismatch_seen = 1'b1;
        end
        void'(masks_due.pop_front());
      end
    end
  end

  initial begin : stimulus
    logic        done;
    logic [31:0] mask;
    int          words;
    int          sent;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.option_byte <= 8'd0;
    in_ch.last_byte <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. The block comes out of reset in IPv4 mode, as does the
    // predictor.
    for (int i = 0; i < N_SCRIPT; i++) begin
      if (SCRIPT[i].kind == ROW_MODE) begin
        write_mode(SCRIPT[i].data[0]);
      end else begin
        push_word(SCRIPT[i].data, SCRIPT[i].last, done, mask);
        if (done) masks_due.push_back(SCRIPT[i].typed ? SCRIPT[i].mask : mask);
      end
    end

    // Random part. The directed part leaves TCP mode set; each later phase
    // flips the mode, so both settings see several hundred words.
    for (int p = 0; p < N_RANDOM_PHASES; p++) begin
      if (p != 0) write_mode(~opt_mode);
      words = 0;
      while (words < WORDS_PER_PHASE) begin
        send_random_area(sent);
        words += sent;
      end
    end

    wait_drained();
    if (!mismatch_seen) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
rtl/iptom_pkg.sv
rtl/iptom_in_if.sv
rtl/iptom_out_if.sv
rtl/iptom_in_stage.sv
rtl/iptom_walk.sv
rtl/ip_tcp_option_mask_core.sv
tb/sv/testbench.sv
